// ===== sv/tcpq_pkg.sv =====
// Shared constants, codes and control types for the two-class priority queue.
// No dependencies; every other file refers to it by scoped names.
package tcpq_pkg;

    localparam int CAPACITY  = 16;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int DATA_W    = 32;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 5;

    localparam logic signed [DATA_W-1:0] THRESH_RESET = 32'sd60;

    localparam logic [KIND_W-1:0] KIND_PUSH     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PRI_PUSH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP      = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic out_hold;
    } t_sts;

endpackage

// ===== sv/two_class_priority_queue_core.sv =====
// Two-class priority queue core: an input transfer is captured into the operand registers, then
// executed across all cells at once into the output register; a new item is accepted only after
// the previous one has executed, and execution waits while the held result is stalled.
// Reset (synchronous, active low) empties the queue and sets the threshold to 60.
// Depends on tcpq_pkg, tcpq_ctrl and tcpq_dp.
module two_class_priority_queue_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [tcpq_pkg::KIND_W-1:0]            i_kind,
    input  logic signed [tcpq_pkg::DATA_W-1:0]     i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [tcpq_pkg::DATA_W-1:0]     o_popped_value,
    output logic [tcpq_pkg::STATUS_W-1:0]          o_status,
    output logic [tcpq_pkg::OCC_W-1:0]             o_occupancy,
    input  logic                                   i_cfg_wr_en,
    input  logic signed [tcpq_pkg::DATA_W-1:0]     i_cfg_wr_data
);

    tcpq_pkg::t_cmd cmd;
    tcpq_pkg::t_sts sts;

    tcpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tcpq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy)
    );

`ifndef SYNTHESIS
    a_stall_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after transfer");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> ##1 o_out_valid)
        else $error("no result after execute");

    a_full_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == tcpq_pkg::STATUS_FULL)
            |-> (o_occupancy == tcpq_pkg::OCC_W'(tcpq_pkg::CAPACITY)))
        else $error("full status with wrong occupancy");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == tcpq_pkg::STATUS_EMPTY)
            |-> (o_occupancy == '0 && o_popped_value == '0))
        else $error("empty status with nonzero result");
`endif

endmodule

// ===== sv/tcpq_ctrl.sv =====
// Controller for the two-class priority queue: input handshake and sequencing.
// Depends on tcpq_pkg for the command and status types.
module tcpq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tcpq_pkg::t_sts i_sts,
    output tcpq_pkg::t_cmd o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_stall;

    always_comb begin
        n_state          = r_state;
        o_cmd.capture    = 1'b0;
        o_cmd.commit     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_sts.out_hold) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_stall <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;

endmodule

// ===== sv/tcpq_dp.sv =====
// Datapath for the two-class priority queue: threshold register, shift-register
// entry cells with per-cell compares, and the output register. Depends on tcpq_pkg.
module tcpq_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tcpq_pkg::t_cmd                         i_cmd,
    output tcpq_pkg::t_sts                         o_sts,
    input  logic [tcpq_pkg::KIND_W-1:0]            i_kind,
    input  logic signed [tcpq_pkg::DATA_W-1:0]     i_value,
    input  logic                                   i_cfg_wr_en,
    input  logic signed [tcpq_pkg::DATA_W-1:0]     i_cfg_wr_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [tcpq_pkg::DATA_W-1:0]     o_popped_value,
    output logic [tcpq_pkg::STATUS_W-1:0]          o_status,
    output logic [tcpq_pkg::OCC_W-1:0]             o_occupancy
);

    logic [tcpq_pkg::KIND_W-1:0]           r_kind;
    logic signed [tcpq_pkg::DATA_W-1:0]    r_value;
    logic signed [tcpq_pkg::DATA_W-1:0]    r_thresh;
    logic signed [tcpq_pkg::DATA_W-1:0]    r_store [tcpq_pkg::CAPACITY];
    logic signed [tcpq_pkg::DATA_W-1:0]    n_store [tcpq_pkg::CAPACITY];
    logic [tcpq_pkg::CNT_W-1:0]            r_count;
    logic [tcpq_pkg::CNT_W-1:0]            n_count;
    logic                                  r_out_valid;
    logic signed [tcpq_pkg::DATA_W-1:0]    r_popped;
    logic signed [tcpq_pkg::DATA_W-1:0]    n_popped;
    logic [tcpq_pkg::STATUS_W-1:0]         r_status;
    logic [tcpq_pkg::STATUS_W-1:0]         n_status;
    logic [tcpq_pkg::OCC_W-1:0]            r_occ;
    logic [31:0]                           cnt_ext;

    logic [tcpq_pkg::CAPACITY-1:0] cell_pri;
    logic [tcpq_pkg::CAPACITY:0]   run_pre;
    logic                          is_full;
    logic                          is_empty;
    logic                          val_pri;
    logic [tcpq_pkg::IDX_W-1:0]    tail_idx;

    assign is_full  = (r_count == tcpq_pkg::CNT_W'(tcpq_pkg::CAPACITY));
    assign is_empty = (r_count == '0);
    assign val_pri  = (r_value >= r_thresh);
    assign tail_idx = r_count[tcpq_pkg::IDX_W-1:0];

    // Per-cell priority flag and prefix of the leading priority run.
    assign run_pre[0] = 1'b1;
    for (genvar g = 0; g < tcpq_pkg::CAPACITY; g++) begin : g_cell
        assign cell_pri[g]  = (tcpq_pkg::CNT_W'(g) < r_count) && (r_store[g] >= r_thresh);
        assign run_pre[g+1] = run_pre[g] & cell_pri[g];
    end

    always_comb begin
        for (int i = 0; i < tcpq_pkg::CAPACITY; i++) begin
            n_store[i] = r_store[i];
        end
        n_count  = r_count;
        n_popped = '0;
        n_status = tcpq_pkg::STATUS_DONE;
        case (r_kind)
            tcpq_pkg::KIND_PUSH, tcpq_pkg::KIND_PRI_PUSH: begin
                if (is_full) begin
                    n_status = tcpq_pkg::STATUS_FULL;
                end else if (r_kind == tcpq_pkg::KIND_PRI_PUSH && val_pri) begin
                    for (int i = 0; i < tcpq_pkg::CAPACITY; i++) begin
                        if (run_pre[i] && !cell_pri[i]) begin
                            n_store[i] = r_value;
                        end else if (!run_pre[i] && i > 0) begin
                            n_store[i] = r_store[i-1];
                        end
                    end
                    n_count = r_count + 1'b1;
                end else begin
                    n_store[tail_idx] = r_value;
                    n_count           = r_count + 1'b1;
                end
            end
            tcpq_pkg::KIND_POP: begin
                if (is_empty) begin
                    n_status = tcpq_pkg::STATUS_EMPTY;
                end else begin
                    n_popped = r_store[0];
                    for (int i = 0; i < tcpq_pkg::CAPACITY - 1; i++) begin
                        n_store[i] = r_store[i+1];
                    end
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = tcpq_pkg::STATUS_DONE;
            end
        endcase
    end

    assign cnt_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh    <= tcpq_pkg::THRESH_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        if (i_cmd.commit) begin
            for (int i = 0; i < tcpq_pkg::CAPACITY; i++) begin
                r_store[i] <= n_store[i];
            end
            r_popped <= n_popped;
            r_status <= n_status;
            r_occ    <= cnt_ext[tcpq_pkg::OCC_W-1:0];
        end
    end

    assign o_sts.out_hold = r_out_valid && i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_status       = r_status;
    assign o_occupancy    = r_occ;

endmodule

// ===== test/tb_two_class_priority_queue_core.sv =====
// Self-checking testbench for two_class_priority_queue_core: push, priority push and pop
// traffic under random idling and stalls, checked against an in-bench queue predictor.
// Depends on tcpq_pkg and the two_class_priority_queue_core RTL.
module tb_two_class_priority_queue_core;

    localparam logic [tcpq_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam longint WORD_MAX = 64'sh7FFF_FFFF;
    localparam longint WORD_MIN = -64'sh8000_0000;

    typedef struct packed {
        logic signed [tcpq_pkg::DATA_W-1:0] popped;
        logic [tcpq_pkg::STATUS_W-1:0]      status;
        logic [tcpq_pkg::OCC_W-1:0]         occ;
    } t_result;

    class tcpq_scoreboard;
        logic signed [tcpq_pkg::DATA_W-1:0] slots [tcpq_pkg::CAPACITY];
        int                                 held;
        logic signed [tcpq_pkg::DATA_W-1:0] threshold;
        t_result                            expected_q [$];
        int                                 errors;
        int                                 checked;
        int                                 full_seen;
        int                                 empty_seen;

        function new();
            held       = 0;
            threshold  = tcpq_pkg::THRESH_RESET;
            errors     = 0;
            checked    = 0;
            full_seen  = 0;
            empty_seen = 0;
        endfunction

        function void set_threshold(input logic signed [tcpq_pkg::DATA_W-1:0] thr);
            threshold = thr;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // advance the queue image by one accepted item and queue its result
        function void note_item(input logic [tcpq_pkg::KIND_W-1:0] kind,
                                input logic signed [tcpq_pkg::DATA_W-1:0] value);
            t_result r;
            int      pos;
            int      i;
            r.popped = '0;
            r.status = tcpq_pkg::STATUS_DONE;
            if (kind == tcpq_pkg::KIND_PUSH || kind == tcpq_pkg::KIND_PRI_PUSH) begin
                if (held >= tcpq_pkg::CAPACITY) begin
                    r.status = tcpq_pkg::STATUS_FULL;
                end else begin
                    pos = held;
                    if (kind == tcpq_pkg::KIND_PRI_PUSH && value >= threshold) begin
                        pos = 0;
                        while (pos < held && slots[pos] >= threshold) pos++;
                    end
                    for (i = held; i > pos; i--) slots[i] = slots[i-1];
                    slots[pos] = value;
                    held++;
                end
            end else if (kind == tcpq_pkg::KIND_POP) begin
                if (held == 0) begin
                    r.status = tcpq_pkg::STATUS_EMPTY;
                end else begin
                    r.popped = slots[0];
                    for (i = 1; i < held; i++) slots[i-1] = slots[i];
                    held--;
                end
            end
            r.occ = held[tcpq_pkg::OCC_W-1:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(input logic signed [tcpq_pkg::DATA_W-1:0] popped,
                                   input logic [tcpq_pkg::STATUS_W-1:0] status,
                                   input logic [tcpq_pkg::OCC_W-1:0] occ);
            t_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: popped %0d status %0d occ %0d",
                         $time, popped, status, occ);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.status == tcpq_pkg::STATUS_FULL) full_seen++;
            if (e.status == tcpq_pkg::STATUS_EMPTY) empty_seen++;
            if (popped !== e.popped) begin
                $display("%0t: popped_value expected %0d got %0d",
                         $time, $signed(e.popped), popped);
                errors++;
            end
            if (status !== e.status) begin
                $display("%0t: status expected %0d got %0d", $time, e.status, status);
                errors++;
            end
            if (occ !== e.occ) begin
                $display("%0t: occupancy expected %0d got %0d", $time, e.occ, occ);
                errors++;
            end
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_in_valid = 1'b0;
    logic                                 o_in_stall;
    logic [tcpq_pkg::KIND_W-1:0]          i_kind = '0;
    logic signed [tcpq_pkg::DATA_W-1:0]   i_value = '0;
    logic                                 o_out_valid;
    logic                                 i_out_stall = 1'b0;
    logic signed [tcpq_pkg::DATA_W-1:0]   o_popped_value;
    logic [tcpq_pkg::STATUS_W-1:0]        o_status;
    logic [tcpq_pkg::OCC_W-1:0]           o_occupancy;
    logic                                 i_cfg_wr_en = 1'b0;
    logic signed [tcpq_pkg::DATA_W-1:0]   i_cfg_wr_data = '0;

    tcpq_scoreboard sb = new();
    int  items_sent = 0;
    int  cfg_writes = 0;
    int  stall_run = 0;
    bit  quiet = 1'b0;

    two_class_priority_queue_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge i_clk) begin
        if (stall_run > 0) begin
            i_out_stall = 1'b1;
            stall_run--;
        end else begin
            i_out_stall = 1'b0;
            stall_run = idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_popped_value, o_status, o_occupancy);
    end

    task automatic send_item(input logic [tcpq_pkg::KIND_W-1:0] kind,
                             input logic signed [tcpq_pkg::DATA_W-1:0] value);
        int n;
        i_in_valid = 1'b1;
        i_kind     = kind;
        i_value    = value;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(kind, value);
        items_sent++;
        @(negedge i_clk);
        n = idle_len();
        if (n > 0) begin
            i_in_valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic signed [tcpq_pkg::DATA_W-1:0] thr);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = thr;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        sb.set_threshold(thr);
        cfg_writes++;
    endtask

    function automatic logic [tcpq_pkg::KIND_W-1:0] pick_kind(input int mode);
        int r;
        int push_pct;
        r = $urandom_range(0, 99);
        push_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 50;
        if (r < 3) return KIND_UNUSED;
        if (r < 3 + push_pct) begin
            return ($urandom_range(0, 9) < 6) ? tcpq_pkg::KIND_PRI_PUSH : tcpq_pkg::KIND_PUSH;
        end
        return tcpq_pkg::KIND_POP;
    endfunction

    function automatic logic signed [tcpq_pkg::DATA_W-1:0] pick_value(
            input logic signed [tcpq_pkg::DATA_W-1:0] thr);
        int     r;
        longint t;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            t = longint'(thr) + longint'($urandom_range(0, 6)) - 3;
            if (t > WORD_MAX) t = WORD_MAX;
            if (t < WORD_MIN) t = WORD_MIN;
            return t[tcpq_pkg::DATA_W-1:0];
        end
        if (r < 7) return $urandom;
        if (r == 7) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return int'($urandom_range(0, 200)) - 100;
    endfunction

    initial begin
        logic signed [tcpq_pkg::DATA_W-1:0] thr_list [6];
        int mode;
        int guard;
        int p;
        int k;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: empty rejection, extremes, filling to capacity, insert positions at reset threshold
        send_item(tcpq_pkg::KIND_POP, 32'sd7);
        send_item(KIND_UNUSED, 32'h5A5A_A5A5);
        send_item(tcpq_pkg::KIND_PRI_PUSH, 32'sd59);
        send_item(tcpq_pkg::KIND_PRI_PUSH, 32'sd60);
        send_item(tcpq_pkg::KIND_PRI_PUSH, 32'h7FFF_FFFF);
        send_item(tcpq_pkg::KIND_PUSH, 32'h8000_0000);
        send_item(tcpq_pkg::KIND_PUSH, 32'h7FFF_FFFF);
        send_item(tcpq_pkg::KIND_PRI_PUSH, 32'h8000_0000);
        send_item(tcpq_pkg::KIND_PUSH, 32'sd0);
        send_item(tcpq_pkg::KIND_PUSH, 32'hFFFF_FFFF);
        send_item(tcpq_pkg::KIND_PRI_PUSH, 32'sd61);
        send_item(tcpq_pkg::KIND_POP, 32'hFFFF_FFFF);
        for (k = 0; k < 6; k++) begin
            if (k[0]) send_item(tcpq_pkg::KIND_PUSH, $urandom);
            else send_item(tcpq_pkg::KIND_PRI_PUSH, 32'sd60 + k);
        end
        send_item(tcpq_pkg::KIND_PUSH, 32'sd1);
        send_item(tcpq_pkg::KIND_PRI_PUSH, 32'h7FFF_FFFF);
        send_item(KIND_UNUSED, 32'hA5A5_5A5A);
        repeat (4) send_item(tcpq_pkg::KIND_POP, $urandom);

        thr_list[0] = 32'h8000_0000;
        thr_list[1] = 32'h7FFF_FFFF;
        thr_list[2] = 32'sd0;
        thr_list[3] = 32'hFFFF_FFFF;
        thr_list[4] = $urandom;
        thr_list[5] = tcpq_pkg::THRESH_RESET;

        mode = 0;
        for (p = 0; p < 6; p++) begin
            wait_drained();
            write_threshold(thr_list[p]);
            for (k = 0; k < 240; k++) begin
                if (k % 50 == 0) quiet = ($urandom_range(0, 4) == 0);
                if ($urandom_range(0, 19) == 0) mode = $urandom_range(0, 2);
                if (k == 120) wait_drained();
                send_item(pick_kind(mode), pick_value(sb.threshold));
            end
        end
        quiet = 1'b0;

        i_in_valid = 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (6) @(negedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, sb.pending());
            sb.errors++;
        end

        $display("Sent %0d items over %0d threshold settings; checked %0d results",
                 items_sent, cfg_writes, sb.checked);
        $display("including %0d pushes refused as full and %0d pops refused as empty",
                 sb.full_seen, sb.empty_seen);
        if (sb.errors == 0) begin
            $display("tb_two_class_priority_queue_core passed");
        end else begin
            $display("tb_two_class_priority_queue_core failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Run did not finish in time");
        $display("tb_two_class_priority_queue_core failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tcpq_pkg.sv
sv/tcpq_ctrl.sv
sv/tcpq_dp.sv
sv/two_class_priority_queue_core.sv
test/tb_two_class_priority_queue_core.sv
